FILE: rtl/tks_pkg.sv
package tks_pkg;

    // keyword table sizes
    localparam int KW_COUNT   = 6;
    localparam int KW_SLOTS   = 8;
    localparam int LEN_W      = 3;
    localparam int CODE_W     = 3;

    // longest count the saturating word length holds
    localparam logic [LEN_W-1:0] LEN_MAX = 3'd7;

    // result codes
    localparam logic [CODE_W-1:0] KW_NONE   = 3'd0;
    localparam logic [CODE_W-1:0] KW_INT    = 3'd1;
    localparam logic [CODE_W-1:0] KW_CHAR   = 3'd2;
    localparam logic [CODE_W-1:0] KW_DOUBLE = 3'd3;
    localparam logic [CODE_W-1:0] KW_FLOAT  = 3'd4;
    localparam logic [CODE_W-1:0] KW_LONG   = 3'd5;
    localparam logic [CODE_W-1:0] KW_VOID   = 3'd6;

    localparam logic [7:0] LINE_FEED = 8'h0A;

    typedef logic [7:0] kw_text_t [KW_COUNT][KW_SLOTS];
    typedef logic [LEN_W-1:0] kw_len_t [KW_COUNT];
    typedef logic [CODE_W-1:0] kw_code_t [KW_COUNT];

    // keyword spellings, zero padded; a letter never equals a pad byte
    localparam kw_text_t KW_TEXT = '{
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h64, 8'h6F, 8'h75, 8'h62, 8'h6C, 8'h65, 8'h00, 8'h00},
        '{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h6C, 8'h6F, 8'h6E, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam kw_len_t KW_LEN = '{3'd3, 3'd4, 3'd6, 3'd5, 3'd4, 3'd4};

    localparam kw_code_t KW_CODE = '{KW_INT, KW_CHAR, KW_DOUBLE, KW_FLOAT, KW_LONG, KW_VOID};

    // ascii letter test
    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

endpackage

FILE: rtl/type_keyword_spotter.sv
// type_keyword_spotter
// Scans a text stream one byte per word on the input channel and reports,
// for every ordinary byte, whether it is a line feed and which C type
// keyword (int, char, double, float, long, void) a letter run ended by it
// spells. Letter bytes yield a result with no keyword and no line feed.
// An input word with end_of_text set yields no result and clears the word.
// Input channel: byte_valid / byte_stall with in_byte and end_of_text.
// Output channel: result_valid / result_stall with newline_seen and
// keyword_found.
// Throughput: one byte per cycle while byte_stall is low; the word state
// (length plus one match flag per keyword) updates once per accepted byte.
// When the receiver stalls, the output register holds its result and a
// one-entry skid register catches the next; byte_stall rises only while
// the skid register is full.
// Reset clears the word state and both result valid flags; no result is
// pending after reset.
module type_keyword_spotter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_valid,
    output logic                       byte_stall,
    input  logic [7:0]                 in_byte,
    input  logic                       end_of_text,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic                       newline_seen,
    output logic [tks_pkg::CODE_W-1:0] keyword_found
);
    import tks_pkg::*;

    logic [LEN_W-1:0]    len_reg, len_next;
    logic [KW_COUNT-1:0] flags_reg, flags_next;
    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic                out_nl_reg, out_nl_next;
    logic [CODE_W-1:0]   out_kw_reg, out_kw_next;
    logic                skid_nl_reg, skid_nl_next;
    logic [CODE_W-1:0]   skid_kw_reg, skid_kw_next;

    logic                accept;
    logic                res_valid;
    logic                res_nl;
    logic [CODE_W-1:0]   res_kw;
    logic [KW_COUNT-1:0] keep;
    logic [CODE_W-1:0]   found;

    assign byte_stall    = skid_valid_reg;
    assign accept        = byte_valid && !skid_valid_reg;
    assign result_valid  = out_valid_reg;
    assign newline_seen  = out_nl_reg;
    assign keyword_found = out_kw_reg;

    // per-keyword prefix test for the incoming letter
    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            keep[k] = (len_reg < KW_LEN[k]) && (KW_TEXT[k][len_reg] == in_byte);
        end
    end

    // keyword that the finished word spells, first match wins
    always_comb
    begin
        found = KW_NONE;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (flags_reg[k] && (len_reg == KW_LEN[k]))
            begin
                found = KW_CODE[k];
            end
        end
    end

    // word state and result of this byte
    always_comb
    begin
        len_next   = len_reg;
        flags_next = flags_reg;
        res_valid  = 1'b0;
        res_nl     = 1'b0;
        res_kw     = KW_NONE;
        if (accept)
        begin
            if (end_of_text)
            begin
                len_next   = '0;
                flags_next = '1;
            end
            else if (is_letter(in_byte))
            begin
                flags_next = flags_reg & keep;
                if (len_reg != LEN_MAX)
                begin
                    len_next = len_reg + 1'b1;
                end
                res_valid = 1'b1;
            end
            else
            begin
                len_next   = '0;
                flags_next = '1;
                res_valid  = 1'b1;
                res_nl     = (in_byte == LINE_FEED);
                res_kw     = found;
            end
        end
    end

    // output register with skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_nl_next     = out_nl_reg;
        out_kw_next     = out_kw_reg;
        skid_nl_next    = skid_nl_reg;
        skid_kw_next    = skid_kw_reg;
        if (!out_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_nl_next     = skid_nl_reg;
                out_kw_next     = skid_kw_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_nl_next    = res_nl;
                out_kw_next    = res_kw;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_nl_next    = res_nl;
            skid_kw_next    = res_kw;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            flags_reg      <= '1;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg        <= len_next;
            flags_reg      <= flags_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_nl_reg  <= out_nl_next;
        out_kw_reg  <= out_kw_next;
        skid_nl_reg <= skid_nl_next;
        skid_kw_reg <= skid_kw_next;
    end

endmodule
